[src/bilinear_icon_scaler_rounded_unit_defines.svh]
`ifndef BILINEAR_ICON_SCALER_ROUNDED_UNIT_DEFINES_SVH
`define BILINEAR_ICON_SCALER_ROUNDED_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define BISR_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the following cycle
`define BISR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bisr_pkg.sv]
package bisr_pkg;

	localparam int ICON_SIZE     = 64;
	localparam int CORNER_RADIUS = 12;
	localparam int MAX_SRC_DIM   = 128;

	// field widths
	localparam int OUT_W      = 6;
	localparam int SRC_W      = 7;
	localparam int DIM_W      = 8;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 4 * CH_W;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 4 * CH_W;
	localparam int CFG_IDX_W  = 1;

	// coordinate arithmetic
	localparam int DEN_W    = $clog2(2 * ICON_SIZE);
	localparam int T_W      = OUT_W + 1 + DIM_W;
	localparam int U_W      = T_W - DEN_W;
	localparam int WT8_W    = 9;
	localparam int WT_W     = 2 * WT8_W - 1;
	localparam int WT_FRAC  = 16;
	localparam int WA_W     = 24;
	localparam int SUM_W    = 32;
	localparam int N_W      = SUM_W + 2;
	localparam int D_W      = WA_W + 1;
	localparam int Q_W      = CH_W;
	localparam int COV_W    = 9;
	localparam int KW       = (CORNER_RADIUS > 0) ? $clog2(CORNER_RADIUS + 1) : 1;

	// source banks, split by column and row parity
	localparam int BANK_DIM   = MAX_SRC_DIM / 2;
	localparam int BH_W       = $clog2(BANK_DIM);
	localparam int BA_W       = 2 * BH_W;
	localparam int BANK_DEPTH = BANK_DIM * BANK_DIM;

	// result queue
	localparam int QDEPTH = 16;
	localparam int QP_W   = $clog2(QDEPTH);
	localparam int QC_W   = QP_W + 1;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'd1;

	typedef logic [0:CORNER_RADIUS][0:CORNER_RADIUS][COV_W-1:0] cov_tab_t;

	typedef struct packed {
		logic             px0;
		logic             px1;
		logic             py0;
		logic             py1;
		logic [WT8_W-1:0] tx;
		logic [WT8_W-1:0] ty;
		logic [COV_W-1:0] cov;
	} samp_ctl_t;

	typedef struct packed {
		logic [2:0][N_W-1:0] num;
		logic [D_W-1:0]      den;
		logic [CH_W-1:0]     alpha;
		logic                zero;
	} div_in_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] alpha;
	} result_t;

	function automatic longint unsigned isqrt_round(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		longint unsigned m;
		r = 0;
		m = n;
		b = 64'd1 << 62;
		while (b > m) b = b >> 2;
		while (b != 0) begin
			if (m >= r + b) begin
				m = m - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (m > r) r = r + 1;
		return r;
	endfunction

	// coverage by corner distance index on each axis; index k stands for 2k-1 half pixels
	function automatic cov_tab_t build_cov();
		cov_tab_t t;
		longint   dx;
		longint   dy;
		longint   rad8;
		longint   c;
		for (int i = 0; i <= CORNER_RADIUS; i++) begin
			for (int j = 0; j <= CORNER_RADIUS; j++) begin
				dx = (i == 0) ? 0 : 2 * i - 1;
				dy = (j == 0) ? 0 : 2 * j - 1;
				rad8 = longint'(isqrt_round(longint'(dx * dx + dy * dy) * 16384));
				c = 128 * (2 * CORNER_RADIUS + 1) - rad8;
				if (c < 0) c = 0;
				if (c > 256) c = 256;
				t[i][j] = COV_W'(c);
			end
		end
		return t;
	endfunction

	localparam cov_tab_t COV_TAB = build_cov();

	localparam logic [OUT_W+1:0] COV_LO = (OUT_W + 2)'(2 * CORNER_RADIUS);
	localparam logic [OUT_W+1:0] COV_HI = (OUT_W + 2)'(2 * ICON_SIZE - 2 * CORNER_RADIUS);

	function automatic logic [KW-1:0] axis_idx(logic [OUT_W-1:0] o);
		logic [OUT_W+1:0] p;
		logic [OUT_W+1:0] d;
		logic [OUT_W+1:0] h;
		p = {1'b0, o, 1'b1};
		if (p < COV_LO) d = COV_LO - p;
		else if (p > COV_HI) d = p - COV_HI;
		else d = '0;
		h = (d + 1'b1) >> 1;
		return h[KW-1:0];
	endfunction

endpackage

[src/bisr_bank.sv]
module bisr_bank
	import bisr_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [BA_W-1:0]  wr_addr,
	input  logic [PIX_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [BA_W-1:0]  rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

[src/bisr_addr.sv]
module bisr_addr
	import bisr_pkg::*;
(
	input  logic [OUT_W-1:0]          out_col,
	input  logic [OUT_W-1:0]          out_row,
	input  logic [DIM_W-1:0]          src_width,
	input  logic [DIM_W-1:0]          src_height,
	output samp_ctl_t                 ctl,
	output logic [3:0][BA_W-1:0]      rd_addr
);

	typedef struct packed {
		logic [SRC_W-1:0] i0;
		logic [SRC_W-1:0] i1;
		logic [WT8_W-1:0] w;
	} axis_t;

	function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] r);
		if (r == '0) return DIM_W'(1);
		if (r > DIM_W'(MAX_SRC_DIM)) return DIM_W'(MAX_SRC_DIM);
		return r;
	endfunction

	// t = (2*out+1)*dim + ICON_SIZE; upper bits are base+1, lower bits the fraction
	function automatic axis_t locate(logic [OUT_W-1:0] o, logic [DIM_W-1:0] d);
		axis_t            a;
		logic [T_W-1:0]   t;
		logic [U_W-1:0]   u;
		logic [U_W-1:0]   dm1;
		logic [U_W-1:0]   v0;
		logic [U_W-1:0]   v1;
		logic [DEN_W-1:0] fr;
		logic [DEN_W+8:0] wn;
		t = T_W'({o, 1'b1}) * T_W'(d) + T_W'(ICON_SIZE);
		u = t[T_W-1:DEN_W];
		fr = t[DEN_W-1:0];
		wn = (DEN_W + 9)'({fr, 8'd0}) + (DEN_W + 9)'(ICON_SIZE);
		dm1 = U_W'(d) - 1'b1;
		v1 = (u < dm1) ? u : dm1;
		if (u == '0) v0 = '0;
		else v0 = ((u - 1'b1) < dm1) ? u - 1'b1 : dm1;
		a.i0 = v0[SRC_W-1:0];
		a.i1 = v1[SRC_W-1:0];
		a.w = wn[DEN_W+8:DEN_W];
		return a;
	endfunction

	axis_t xa;
	axis_t ya;
	logic [1:0][BH_W-1:0] xh;
	logic [1:0][BH_W-1:0] yh;

	assign xa = locate(out_col, eff_dim(src_width));
	assign ya = locate(out_row, eff_dim(src_height));

	// each parity bank serves whichever neighbor has that parity
	always_comb begin
		xh[0] = (xa.i0[0] == 1'b0) ? xa.i0[SRC_W-1:1] : xa.i1[SRC_W-1:1];
		xh[1] = (xa.i0[0] == 1'b1) ? xa.i0[SRC_W-1:1] : xa.i1[SRC_W-1:1];
		yh[0] = (ya.i0[0] == 1'b0) ? ya.i0[SRC_W-1:1] : ya.i1[SRC_W-1:1];
		yh[1] = (ya.i0[0] == 1'b1) ? ya.i0[SRC_W-1:1] : ya.i1[SRC_W-1:1];
		rd_addr[0] = {yh[0], xh[0]};
		rd_addr[1] = {yh[0], xh[1]};
		rd_addr[2] = {yh[1], xh[0]};
		rd_addr[3] = {yh[1], xh[1]};
	end

	always_comb begin
		ctl.px0 = xa.i0[0];
		ctl.px1 = xa.i1[0];
		ctl.py0 = ya.i0[0];
		ctl.py1 = ya.i1[0];
		ctl.tx = xa.w;
		ctl.ty = ya.w;
		ctl.cov = COV_TAB[axis_idx(out_col)][axis_idx(out_row)];
	end

endmodule

[src/bisr_blend.sv]
module bisr_blend
	import bisr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_s1,
	input  samp_ctl_t             ctl_s1,
	input  logic [3:0][PIX_W-1:0] pix_s1,
	output logic                  div_v,
	output div_in_t               div_in
);

	localparam logic [WT8_W-1:0]   WT_ONE     = WT8_W'(256);
	localparam logic [WA_W:0]      ALPHA_HALF = (WA_W + 1)'(32768);

	// stage 1: neighbor select and bilinear weights
	logic [3:0][PIX_W-1:0] sel;
	logic [WT8_W-1:0]      wx0;
	logic [WT8_W-1:0]      wy0;
	logic [3:0][WT_W-1:0]  wt;

	always_comb begin
		sel[0] = pix_s1[{ctl_s1.py0, ctl_s1.px0}];
		sel[1] = pix_s1[{ctl_s1.py0, ctl_s1.px1}];
		sel[2] = pix_s1[{ctl_s1.py1, ctl_s1.px0}];
		sel[3] = pix_s1[{ctl_s1.py1, ctl_s1.px1}];
		wx0 = WT_ONE - ctl_s1.tx;
		wy0 = WT_ONE - ctl_s1.ty;
		wt[0] = WT_W'(wx0) * WT_W'(wy0);
		wt[1] = WT_W'(ctl_s1.tx) * WT_W'(wy0);
		wt[2] = WT_W'(wx0) * WT_W'(ctl_s1.ty);
		wt[3] = WT_W'(ctl_s1.tx) * WT_W'(ctl_s1.ty);
	end

	logic                  v_s2;
	logic [3:0][PIX_W-1:0] pix_s2;
	logic [3:0][WT_W-1:0]  wt_s2;
	logic [COV_W-1:0]      cov_s2;

	// stage 2: weighted alpha
	logic [3:0][WA_W-1:0] wa;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wa[i] = WA_W'(wt_s2[i]) * WA_W'(pix_s2[i][31:24]);
		end
	end

	logic                       v_s3;
	logic [3:0][WA_W-1:0]       wa_s3;
	logic [3:0][2:0][CH_W-1:0]  rgb_s3;
	logic [COV_W-1:0]           cov_s3;

	// stage 3: color products and alpha sum
	logic [3:0][2:0][SUM_W-1:0] pr;
	logic [WA_W-1:0]            asum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int c = 0; c < 3; c++) begin
				pr[i][c] = SUM_W'(wa_s3[i]) * SUM_W'(rgb_s3[i][c]);
			end
		end
		asum = wa_s3[0] + wa_s3[1] + wa_s3[2] + wa_s3[3];
	end

	logic                       v_s4;
	logic [3:0][2:0][SUM_W-1:0] pr_s4;
	logic [WA_W-1:0]            a_s4;
	logic [COV_W-1:0]           cov_s4;

	// stage 4: color sums, divider operands, rounded alpha
	logic [2:0][N_W-1:0] num;
	logic [SUM_W-1:0]    csum;
	logic [WA_W:0]       am;
	logic [CH_W-1:0]     a8;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			csum = pr_s4[0][c] + pr_s4[1][c] + pr_s4[2][c] + pr_s4[3][c];
			num[c] = N_W'({csum, 1'b0}) + N_W'(a_s4);
		end
		am = (WA_W + 1)'(a_s4) + ALPHA_HALF;
		a8 = (am[WA_W:WT_FRAC] > (WA_W + 1 - WT_FRAC)'(255)) ? CH_W'(255)
			: am[WT_FRAC+CH_W-1:WT_FRAC];
	end

	logic                v_s5;
	logic [2:0][N_W-1:0] num_s5;
	logic [D_W-1:0]      den_s5;
	logic [CH_W-1:0]     a8_s5;
	logic [COV_W-1:0]    cov_s5;
	logic                zero_s5;

	// stage 5: corner coverage applied to alpha
	logic [CH_W+COV_W-1:0] fa;

	always_comb begin
		fa = (CH_W + COV_W)'(a8_s5) * (CH_W + COV_W)'(cov_s5) + (CH_W + COV_W)'(128);
		div_in.num = num_s5;
		div_in.den = den_s5;
		div_in.alpha = (fa[CH_W+COV_W-1:8] > COV_W'(255)) ? CH_W'(255) : fa[CH_W+7:8];
		div_in.zero = zero_s5;
	end

	assign div_v = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2 <= sel;
		wt_s2 <= wt;
		cov_s2 <= ctl_s1.cov;
		wa_s3 <= wa;
		for (int i = 0; i < 4; i++) begin
			rgb_s3[i][0] <= pix_s2[i][23:16];
			rgb_s3[i][1] <= pix_s2[i][15:8];
			rgb_s3[i][2] <= pix_s2[i][7:0];
		end
		cov_s3 <= cov_s2;
		pr_s4 <= pr;
		a_s4 <= asum;
		cov_s4 <= cov_s3;
		num_s5 <= num;
		den_s5 <= {a_s4, 1'b0};
		a8_s5 <= a8;
		cov_s5 <= cov_s4;
		zero_s5 <= (a_s4 == '0);
	end

endmodule

[src/bisr_div.sv]
module bisr_div
	import bisr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_v,
	input  div_in_t din,
	output logic    out_v,
	output result_t res
);

	typedef struct packed {
		logic [2:0][N_W-1:0] rem;
		logic [2:0][Q_W-1:0] quo;
		logic [D_W-1:0]      den;
		logic [CH_W-1:0]     alpha;
		logic                zero;
	} dstg_t;

	// one quotient bit per stage; quotient never exceeds 255 since color <= 255 * alpha
	dstg_t [Q_W-1:0] stg_q;
	dstg_t [Q_W-1:0] nxt;
	logic  [Q_W-1:0] v_q;

	always_comb begin
		dstg_t          src;
		logic [N_W-1:0] dsh;
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				src.rem = din.num;
				src.quo = '0;
				src.den = din.den;
				src.alpha = din.alpha;
				src.zero = din.zero;
			end else begin
				src = stg_q[k-1];
			end
			dsh = N_W'(src.den) << (Q_W - 1 - k);
			nxt[k] = src;
			for (int c = 0; c < 3; c++) begin
				if (src.rem[c] >= dsh) begin
					nxt[k].rem[c] = src.rem[c] - dsh;
					nxt[k].quo[c][Q_W-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		stg_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[Q_W-2:0], in_v};
		end
	end

	always_comb begin
		res.alpha = stg_q[Q_W-1].alpha;
		res.red = stg_q[Q_W-1].zero ? '0 : stg_q[Q_W-1].quo[0];
		res.green = stg_q[Q_W-1].zero ? '0 : stg_q[Q_W-1].quo[1];
		res.blue = stg_q[Q_W-1].zero ? '0 : stg_q[Q_W-1].quo[2];
	end

	assign out_v = v_q[Q_W-1];

endmodule

[src/bilinear_icon_scaler_rounded_unit.sv]
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tuser: kind; tdata: load pixel or sample request
// m_*      out  m_tvalid/m_tready   tdata: res_alpha, res_red, res_green, res_blue
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (src_width, src_height)
//
// One item per cycle sustained while s_tready is high; a sample result passes the
// bank read, blend and divider stages. The rate is set by the four parity banks of
// the image, one read port each, which return the four bilinear neighbors together.
// Up to 16 samples may be in flight; s_tready drops only when 16 accepted samples are undelivered.
// Loads write in their accept cycle, so a sample may read that pixel in the next cycle.
// Reset clears control state and sets both dimensions to 128; pixels are undefined.
`include "bilinear_icon_scaler_rounded_unit_defines.svh"

module bilinear_icon_scaler_rounded_unit
	import bisr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [6:0] src_col, [13:7] src_row, [21:14] in_alpha, [29:22] in_red,
	// [37:30] in_green, [45:38] in_blue, [51:46] out_col, [57:52] out_row
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] res_alpha, [15:8] res_red, [23:16] res_green, [31:24] res_blue
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data
);

	logic [SRC_W-1:0] ld_col;
	logic [SRC_W-1:0] ld_row;
	logic [PIX_W-1:0] ld_pix;
	logic [OUT_W-1:0] out_col;
	logic [OUT_W-1:0] out_row;

	assign ld_col = s_tdata[6:0];
	assign ld_row = s_tdata[13:7];
	// stored word is alpha, red, green, blue from the top byte down
	assign ld_pix = {s_tdata[21:14], s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};
	assign out_col = s_tdata[51:46];
	assign out_row = s_tdata[57:52];

	logic in_acc;
	logic load_acc;
	logic samp_acc;
	logic out_acc;

	assign in_acc = s_tvalid & s_tready;
	assign load_acc = in_acc & (s_tuser == KIND_LOAD);
	assign samp_acc = in_acc & (s_tuser == KIND_SAMPLE);

	// configuration
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(MAX_SRC_DIM);
			height_q <= DIM_W'(MAX_SRC_DIM);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  width_q <= cfg_data;
				CFG_SRC_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// neighbor addresses
	samp_ctl_t            ctl_s0;
	samp_ctl_t            ctl_s1;
	logic [3:0][BA_W-1:0] rd_addr;
	logic                 samp_v_s1;

	bisr_addr u_addr (
		.out_col    (out_col),
		.out_row    (out_row),
		.src_width  (width_q),
		.src_height (height_q),
		.ctl        (ctl_s0),
		.rd_addr    (rd_addr)
	);

	// source image in four banks by {row parity, column parity}
	logic [1:0]            ld_bank;
	logic [3:0][PIX_W-1:0] pix_s1;

	assign ld_bank = {ld_row[0], ld_col[0]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bisr_bank u_bank (
			.clk     (clk),
			.wr_en   (load_acc && (ld_bank == 2'(b))),
			.wr_addr ({ld_row[SRC_W-1:1], ld_col[SRC_W-1:1]}),
			.wr_data (ld_pix),
			.rd_en   (samp_acc),
			.rd_addr (rd_addr[b]),
			.rd_data (pix_s1[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_v_s1 <= 1'b0;
		end else begin
			samp_v_s1 <= samp_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (samp_acc) ctl_s1 <= ctl_s0;
	end

	// blending and division
	logic    dv_v;
	div_in_t dv_in;
	logic    res_v;
	result_t res;

	bisr_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (samp_v_s1),
		.ctl_s1 (ctl_s1),
		.pix_s1 (pix_s1),
		.div_v  (dv_v),
		.div_in (dv_in)
	);

	bisr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (dv_v),
		.din    (dv_in),
		.out_v  (res_v),
		.res    (res)
	);

	// result queue; occupancy counts samples accepted and not yet delivered
	result_t          fifo_q [QDEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  cnt_q;
	logic [QC_W-1:0]  occ_q;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata = fifo_q[rd_ptr_q];
	assign out_acc = m_tvalid & m_tready;
	assign s_tready = (occ_q != QC_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (res_v) fifo_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QP_W'(res_v);
			rd_ptr_q <= rd_ptr_q + QP_W'(out_acc);
			cnt_q <= cnt_q + QC_W'(res_v) - QC_W'(out_acc);
			occ_q <= occ_q + QC_W'(samp_acc) - QC_W'(out_acc);
		end
	end

	`BISR_ASSERT(a_occ_bound, clk, arst_n, 1'b1, occ_q <= QC_W'(QDEPTH), "occupancy above queue depth")
	`BISR_ASSERT(a_queue_le_occ, clk, arst_n, 1'b1, cnt_q <= occ_q, "queued results exceed samples in flight")
	`BISR_ASSERT(a_no_orphan, clk, arst_n, res_v, occ_q != '0, "result with no sample in flight")
	`BISR_ASSERT_NXT(a_read_issued, clk, arst_n, samp_acc, samp_v_s1, "sample read not issued")

endmodule
